[rtl/bvs_pkg.sv]
// Shared widths, command and status codes, and the result record of the vector store.
package bvs_pkg;

    localparam int CW = 9;
    localparam int PW = 8;

    localparam logic [2:0] CMD_APPEND = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_ERASE  = 3'd2;
    localparam logic [2:0] CMD_SWAP   = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;
    localparam logic [2:0] CMD_CLEAR  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [CW-1:0] CAP_RESET = 9'd256;

    typedef struct packed {
        logic [1:0]    status;
        logic [CW-1:0] size;
        logic          rd_sel;
    } t_fin;

endpackage

[rtl/bounded_vector_store_core.sv]
// Top level of the bounded vector store: capacity register, sequencer, element RAM, result stage.
//
// The input channel carries one command item: append, remove last, erase at a position,
// swap two positions, read at a position, or clear. The output channel returns exactly one
// result item per command: a status, the data read and the element count after the step.
// Both channels use valid and ready; an item moves when both are high.
// The capacity register is written through i_cfg_we and i_cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this. Commands run one at
// a time on a single RAM with one write and one registered read port. Append, remove, clear,
// read and every refused command go from idle straight to the finish state, which loads the
// result register once the output is free and returns to idle. Swap passes through its swap
// states before it, as its two reads and two writes share the ports. Erase repeats its erase
// state for each element behind the erased position, since the tail moves down one entry per
// cycle. The result register sits between the sequencer and the receiver, so a new item is
// accepted while the previous result waits; a stalled receiver holds the sequencer only when
// its next result is ready. Synchronous active-low reset empties the store, drops any pending
// result and sets the capacity to 256; the RAM itself is not cleared.
module bounded_vector_store_core
    import bvs_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CW-1:0]         i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_command,
    input  logic [DATA_WIDTH-1:0] i_data_in,
    input  logic [PW-1:0]         i_pos_a,
    input  logic [PW-1:0]         i_pos_b,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic [DATA_WIDTH-1:0] o_read_data,
    output logic [CW-1:0]         o_size_now
);

    localparam int AW = $clog2(DEPTH);

    logic [CW-1:0]         r_cap;
    logic                  r_ov;
    logic [1:0]            r_status;
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [CW-1:0]         r_size;

    logic                  w_out_free;
    logic                  w_fin_valid;
    t_fin                  w_fin;
    logic                  w_ram_we;
    logic [AW-1:0]         w_ram_waddr;
    logic [DATA_WIDTH-1:0] w_ram_wdata;
    logic                  w_ram_re;
    logic [AW-1:0]         w_ram_raddr;
    logic [DATA_WIDTH-1:0] w_ram_rdata;

    assign w_out_free = !r_ov || i_out_ready;

    bvs_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_data_in   (i_data_in),
        .i_pos_a     (i_pos_a),
        .i_pos_b     (i_pos_b),
        .i_cap       (r_cap),
        .i_out_free  (w_out_free),
        .o_fin_valid (w_fin_valid),
        .o_fin       (w_fin),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    bvs_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
            r_ov  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (w_fin_valid) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
        if (w_fin_valid) begin
            r_status <= w_fin.status;
            r_rdata  <= w_fin.rd_sel ? w_ram_rdata : '0;
            r_size   <= w_fin.size;
        end
    end

    assign o_out_valid = r_ov;
    assign o_status    = r_status;
    assign o_read_data = r_rdata;
    assign o_size_now  = r_size;

    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_size_now) <= DEPTH))
        else $error("result count exceeds the store depth");

    a_rdata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_read_data == '0))
        else $error("read data is nonzero on a refused command");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("a second item was accepted before the first one finished");

endmodule

[rtl/bvs_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module bvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bvs_ctrl.sv]
// Command sequencer: decodes each item, drives the element RAM and keeps the count.
module bvs_ctrl
    import bvs_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [2:0]               i_command,
    input  logic [DATA_WIDTH-1:0]    i_data_in,
    input  logic [PW-1:0]            i_pos_a,
    input  logic [PW-1:0]            i_pos_b,
    input  logic [CW-1:0]            i_cap,
    input  logic                     i_out_free,
    output logic                     o_fin_valid,
    output t_fin                     o_fin,
    output logic                     o_ram_we,
    output logic [$clog2(DEPTH)-1:0] o_ram_waddr,
    output logic [DATA_WIDTH-1:0]    o_ram_wdata,
    output logic                     o_ram_re,
    output logic [$clog2(DEPTH)-1:0] o_ram_raddr,
    input  logic [DATA_WIDTH-1:0]    i_ram_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int XW = (AW > CW) ? AW : CW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWAP1 = 3'd1;
    localparam logic [2:0] S_SWAP2 = 3'd2;
    localparam logic [2:0] S_SWAP3 = 3'd3;
    localparam logic [2:0] S_ERASE = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    function automatic logic [AW-1:0] to_addr(input logic [CW-1:0] v);
        logic [XW-1:0] x;
        x = XW'(v);
        return x[AW-1:0];
    endfunction

    logic [2:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [1:0]            r_status, n_status;
    logic                  r_rd_sel, n_rd_sel;
    logic [PW-1:0]         r_pa, n_pa;
    logic [PW-1:0]         r_pb, n_pb;
    logic [CW-1:0]         r_idx, n_idx;
    logic [DATA_WIDTH-1:0] r_tmp, n_tmp;

    logic          w_a_ok;
    logic          w_b_ok;
    logic          w_full;
    logic [CW-1:0] w_pa_x;
    logic [CW-1:0] w_pa_next;
    logic [CW:0]   w_idx_next2;

    assign w_pa_x      = CW'(i_pos_a);
    assign w_pa_next   = w_pa_x + CW'(1);
    assign w_a_ok      = w_pa_x < r_count;
    assign w_b_ok      = CW'(i_pos_b) < r_count;
    assign w_full      = (r_count >= i_cap) || (32'(r_count) >= DEPTH);
    assign w_idx_next2 = {1'b0, r_idx} + (CW+1)'(2);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_status    = r_status;
        n_rd_sel    = r_rd_sel;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_idx       = r_idx;
        n_tmp       = r_tmp;
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = '0;
        o_ram_re    = 1'b0;
        o_ram_raddr = '0;
        o_fin_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status = ST_OK;
                    n_rd_sel = 1'b0;
                    n_pa     = i_pos_a;
                    n_pb     = i_pos_b;
                    n_state  = S_FIN;
                    case (i_command)
                        CMD_APPEND: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = to_addr(r_count);
                                o_ram_wdata = i_data_in;
                                n_count     = r_count + CW'(1);
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        CMD_ERASE: begin
                            if (!w_a_ok) begin
                                n_status = ST_RANGE;
                            end else if (w_pa_next < r_count) begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = to_addr(w_pa_next);
                                n_idx       = w_pa_x;
                                n_state     = S_ERASE;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        CMD_SWAP: begin
                            if (!w_a_ok || !w_b_ok) begin
                                n_status = ST_RANGE;
                            end else begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = to_addr(w_pa_x);
                                n_state     = S_SWAP1;
                            end
                        end
                        CMD_READ: begin
                            if (!w_a_ok) begin
                                n_status = ST_RANGE;
                            end else begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = to_addr(w_pa_x);
                                n_rd_sel    = 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_SWAP1: begin
                n_tmp       = i_ram_rdata;
                o_ram_re    = 1'b1;
                o_ram_raddr = to_addr(CW'(r_pb));
                n_state     = S_SWAP2;
            end
            S_SWAP2: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = to_addr(CW'(r_pa));
                o_ram_wdata = i_ram_rdata;
                n_state     = S_SWAP3;
            end
            S_SWAP3: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = to_addr(CW'(r_pb));
                o_ram_wdata = r_tmp;
                n_state     = S_FIN;
            end
            S_ERASE: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = to_addr(r_idx);
                o_ram_wdata = i_ram_rdata;
                if (w_idx_next2 < {1'b0, r_count}) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = to_addr(w_idx_next2[CW-1:0]);
                    n_idx       = r_idx + CW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_fin_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_status <= n_status;
        r_rd_sel <= n_rd_sel;
        r_pa     <= n_pa;
        r_pb     <= n_pb;
        r_idx    <= n_idx;
        r_tmp    <= n_tmp;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_fin.status  = r_status;
    assign o_fin.size    = r_count;
    assign o_fin.rd_sel  = r_rd_sel;

endmodule
